FILE: src/pgf_pkg.sv
// shared constants and width helpers for the pair gravity force block
`default_nettype none
package pgf_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int MASS_BITS_DEF = 32;
  localparam int RADIUS_BITS = 23;
  localparam int DIST_BITS = 25;
  localparam int GAIN_W = 32;
  localparam int FORCE_W = 64;
  localparam int FRAC_SHIFT = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd28665814;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  function automatic int den_w(input int c);
    int sum_w;
    int d2_w;
    int r2_w;
    sum_w = 2 * c + 1;
    d2_w = (sum_w > 64) ? 64 : sum_w;
    r2_w = 2 * (RADIUS_BITS + 1);
    return (d2_w > r2_w) ? d2_w : r2_w;
  endfunction

  function automatic int num_w(input int m);
    return 2 * m + GAIN_W - FRAC_SHIFT;
  endfunction
endpackage
`default_nettype wire

FILE: src/pgf_fifo.sv
// small register queue used between the front, back and result ports
`default_nettype none
module pgf_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  localparam int PW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic do_wr;
  logic do_rd;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end
endmodule
`default_nettype wire

FILE: src/pgf_front.sv
// front pipeline: differences, squares, clamp decision and gain product
`default_nettype none
module pgf_front #(
  parameter int COORD_BITS = pgf_pkg::COORD_BITS_DEF,
  parameter int MASS_BITS = pgf_pkg::MASS_BITS_DEF,
  localparam int DEN_W = pgf_pkg::den_w(COORD_BITS),
  localparam int N_W = pgf_pkg::num_w(MASS_BITS),
  localparam int MID_W = N_W + DEN_W + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [COORD_BITS-1:0]  a_x,
  input  wire logic signed [COORD_BITS-1:0]  a_y,
  input  wire logic [pgf_pkg::RADIUS_BITS-1:0] a_radius,
  input  wire logic [MASS_BITS-1:0]          a_mass,
  input  wire logic signed [COORD_BITS-1:0]  b_x,
  input  wire logic signed [COORD_BITS-1:0]  b_y,
  input  wire logic [pgf_pkg::RADIUS_BITS-1:0] b_radius,
  input  wire logic [MASS_BITS-1:0]          b_mass,
  input  wire logic [pgf_pkg::GAIN_W-1:0]    gain,
  input  wire logic                          mid_full,
  output logic                               mid_push,
  output logic [MID_W-1:0]                   mid_data
);
  localparam int C = COORD_BITS;
  localparam int R_W = pgf_pkg::RADIUS_BITS + 1;
  localparam int SUM_W = 2 * C + 1;
  localparam int D2_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int P_W = 2 * MASS_BITS;

  logic v1, v2, v3, v4;
  logic en;

  logic [C-1:0] dx1, dy1;
  logic [R_W-1:0] rs1;
  logic [MASS_BITS-1:0] am1, bm1;

  logic [2*C-1:0] sx2, sy2;
  logic [2*R_W-1:0] r22;
  logic [P_W-1:0] p2;

  logic [DEN_W-1:0] den3;
  logic clamp3, zero3;
  logic [63:0] plo3, phi3;

  logic [DEN_W-1:0] den4;
  logic clamp4, zero4;
  logic [N_W-1:0] num4;

  logic signed [C:0] dxs, dys;
  logic [SUM_W-1:0] sum_c;
  logic [D2_W-1:0] d2_c;
  logic [DEN_W-1:0] d2_e, r2_e, den_c;
  logic clamp_c;
  logic [63:0] p64, plo_c, phi_c;
  logic [95:0] n96;

  assign en = ~v4 | ~mid_full;
  assign full = ~en;
  assign mid_push = v4 & ~mid_full;
  assign mid_data = {zero4, clamp4, den4, num4};

  assign dxs = {a_x[C-1], a_x} - {b_x[C-1], b_x};
  assign dys = {a_y[C-1], a_y} - {b_y[C-1], b_y};

  assign sum_c = {1'b0, sx2} + {1'b0, sy2};
  generate
    if (SUM_W > 64) begin : g_sat
      assign d2_c = (|sum_c[SUM_W-1:64]) ? '1 : sum_c[63:0];
    end else begin : g_nosat
      assign d2_c = sum_c;
    end
  endgenerate
  assign d2_e = DEN_W'(d2_c);
  assign r2_e = DEN_W'(r22);
  assign clamp_c = d2_e < r2_e;
  assign den_c = clamp_c ? r2_e : d2_e;

  assign p64 = 64'(p2);
  assign plo_c = p64[31:0] * gain;
  assign phi_c = p64[63:32] * gain;
  assign n96 = {32'b0, plo3} + {phi3, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= dxs[C] ? C'(-dxs) : dxs[C-1:0];
      dy1 <= dys[C] ? C'(-dys) : dys[C-1:0];
      rs1 <= {1'b0, a_radius} + {1'b0, b_radius};
      am1 <= a_mass;
      bm1 <= b_mass;
      sx2 <= dx1 * dx1;
      sy2 <= dy1 * dy1;
      r22 <= rs1 * rs1;
      p2 <= am1 * bm1;
      den3 <= den_c;
      clamp3 <= clamp_c;
      zero3 <= (den_c == '0);
      plo3 <= plo_c;
      phi3 <= phi_c;
      den4 <= den3;
      clamp4 <= clamp3;
      zero4 <= zero3;
      num4 <= n96[pgf_pkg::FRAC_SHIFT+N_W-1:pgf_pkg::FRAC_SHIFT];
    end
  end
endmodule
`default_nettype wire

FILE: src/pgf_back.sv
// back pipeline: one division bit and one square root digit per stage, each until its result is complete
`default_nettype none
module pgf_back #(
  parameter int COORD_BITS = pgf_pkg::COORD_BITS_DEF,
  parameter int MASS_BITS = pgf_pkg::MASS_BITS_DEF,
  localparam int DEN_W = pgf_pkg::den_w(COORD_BITS),
  localparam int N_W = pgf_pkg::num_w(MASS_BITS),
  localparam int MID_W = N_W + DEN_W + 2,
  localparam int RES_W = pgf_pkg::DIST_BITS + pgf_pkg::FORCE_W + 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             mid_empty,
  input  wire logic [MID_W-1:0] mid_data,
  output logic                  mid_pop,
  input  wire logic             out_full,
  output logic                  out_push,
  output logic [RES_W-1:0]      out_data
);
  localparam int Q_W = (N_W > 64) ? 64 : N_W;
  localparam int HI_W = N_W - Q_W;
  localparam int SQ_W = (DEN_W + 1) / 2;
  localparam int SR_W = SQ_W + 3;
  localparam int NSTG = (Q_W > SQ_W) ? Q_W : SQ_W;
  localparam int DB = pgf_pkg::DIST_BITS;

  logic en;
  logic [N_W-1:0] num0;
  logic [DEN_W-1:0] den0;
  logic clamp0, zero0;
  logic [DEN_W-1:0] rem0;
  logic sat0;

  logic st_v [1:NSTG];
  logic [DEN_W-1:0] st_den [1:NSTG];
  logic [DEN_W-1:0] st_rem [1:NSTG];
  logic [Q_W-1:0] st_nsh [1:NSTG];
  logic [Q_W-1:0] st_q [1:NSTG];
  logic [2*SQ_W-1:0] st_src [1:NSTG];
  logic [SR_W-1:0] st_srem [1:NSTG];
  logic [SQ_W-1:0] st_root [1:NSTG];
  logic st_sat [1:NSTG];
  logic st_clamp [1:NSTG];
  logic st_zero [1:NSTG];

  logic [DB-1:0] dist_f;
  logic [pgf_pkg::FORCE_W-1:0] force_f;

  assign {zero0, clamp0, den0, num0} = mid_data;
  assign en = ~st_v[NSTG] | ~out_full;
  assign mid_pop = en & ~mid_empty;
  assign out_push = st_v[NSTG] & ~out_full;

  generate
    if (HI_W > 0) begin : g_hi
      assign rem0 = DEN_W'(num0[N_W-1:Q_W]);
      assign sat0 = rem0 >= den0;
    end else begin : g_nohi
      assign rem0 = '0;
      assign sat0 = 1'b0;
    end
  endgenerate

  genvar s;
  generate
    for (s = 0; s < NSTG; s++) begin : g_stg
      logic c_v, c_sat, c_clamp, c_zero;
      logic [DEN_W-1:0] c_den, c_rem, n_rem;
      logic [Q_W-1:0] c_nsh, c_q, n_nsh, n_q;
      logic [2*SQ_W-1:0] c_src, n_src;
      logic [SR_W-1:0] c_srem, n_srem;
      logic [SQ_W-1:0] c_root, n_root;

      if (s == 0) begin : g_first
        assign c_v = ~mid_empty;
        assign c_sat = sat0;
        assign c_clamp = clamp0;
        assign c_zero = zero0;
        assign c_den = den0;
        assign c_rem = rem0;
        assign c_nsh = num0[Q_W-1:0];
        assign c_q = '0;
        assign c_src = (2*SQ_W)'(den0);
        assign c_srem = '0;
        assign c_root = '0;
      end else begin : g_mid
        assign c_v = st_v[s];
        assign c_sat = st_sat[s];
        assign c_clamp = st_clamp[s];
        assign c_zero = st_zero[s];
        assign c_den = st_den[s];
        assign c_rem = st_rem[s];
        assign c_nsh = st_nsh[s];
        assign c_q = st_q[s];
        assign c_src = st_src[s];
        assign c_srem = st_srem[s];
        assign c_root = st_root[s];
      end

      if (s < Q_W) begin : g_div
        logic [DEN_W:0] t;
        logic ge;
        assign t = {c_rem, c_nsh[Q_W-1]};
        assign ge = t >= {1'b0, c_den};
        assign n_rem = ge ? DEN_W'(t - {1'b0, c_den}) : t[DEN_W-1:0];
        assign n_nsh = c_nsh << 1;
        assign n_q = {c_q[Q_W-2:0], ge};
      end else begin : g_nodiv
        assign n_rem = c_rem;
        assign n_nsh = c_nsh;
        assign n_q = c_q;
      end

      if (s < SQ_W) begin : g_sq
        logic [SR_W-1:0] t;
        logic [SR_W-1:0] trial;
        logic ge;
        assign t = {c_srem[SR_W-3:0], c_src[2*SQ_W-1 -: 2]};
        assign trial = SR_W'({c_root, 2'b01});
        assign ge = t >= trial;
        assign n_srem = ge ? t - trial : t;
        assign n_root = {c_root[SQ_W-2:0], ge};
        assign n_src = c_src << 2;
      end else begin : g_nosq
        assign n_srem = c_srem;
        assign n_root = c_root;
        assign n_src = c_src;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          st_v[s+1] <= 1'b0;
        end else if (en) begin
          st_v[s+1] <= c_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_sat[s+1] <= c_sat;
          st_clamp[s+1] <= c_clamp;
          st_zero[s+1] <= c_zero;
          st_den[s+1] <= c_den;
          st_rem[s+1] <= n_rem;
          st_nsh[s+1] <= n_nsh;
          st_q[s+1] <= n_q;
          st_src[s+1] <= n_src;
          st_srem[s+1] <= n_srem;
          st_root[s+1] <= n_root;
        end
      end
    end
  endgenerate

  generate
    if (SQ_W > DB) begin : g_dsat
      assign dist_f = (|st_root[NSTG][SQ_W-1:DB]) ? '1 : st_root[NSTG][DB-1:0];
    end else begin : g_dfit
      assign dist_f = DB'(st_root[NSTG]);
    end
  endgenerate

  assign force_f = (st_zero[NSTG] | st_sat[NSTG]) ? '1 : pgf_pkg::FORCE_W'(st_q[NSTG]);
  assign out_data = {dist_f, force_f, st_clamp[NSTG], st_zero[NSTG]};
endmodule
`default_nettype wire

FILE: src/pair_gravity_force.sv
// top level of the pair gravity force block
//
// Input side is a queue: present both bodies and raise push; the pair is taken
// at a clock edge where full is low. Result side is a queue as well: while
// empty is low the oldest result (distance, force_res, clamped, status) is on
// the ports, and pop at an edge takes it. The gain register is written through
// cfg_valid/cfg_data; cfg_ready is always high, write only while the block idles.
// One pair enters per cycle and one result leaves per cycle when nobody stalls.
// With the default widths a pair passes 4 front stages, the queue between front
// and back, 64 back stages (one quotient bit of the 64-bit force per stage,
// with the 25 root digits of the distance done in the first stages alongside)
// and the result queue.
// A stalled receiver fills the result queue, then the back pipeline freezes,
// the middle queue fills, the front freezes and full rises.
// Reset empties every queue and pipeline and loads the default gain; the block
// takes items in the cycle after reset falls.
`default_nettype none
module pair_gravity_force #(
  parameter int COORD_BITS = pgf_pkg::COORD_BITS_DEF,
  parameter int MASS_BITS = pgf_pkg::MASS_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [COORD_BITS-1:0]    a_x,
  input  wire logic signed [COORD_BITS-1:0]    a_y,
  input  wire logic [pgf_pkg::RADIUS_BITS-1:0] a_radius,
  input  wire logic [MASS_BITS-1:0]            a_mass,
  input  wire logic signed [COORD_BITS-1:0]    b_x,
  input  wire logic signed [COORD_BITS-1:0]    b_y,
  input  wire logic [pgf_pkg::RADIUS_BITS-1:0] b_radius,
  input  wire logic [MASS_BITS-1:0]            b_mass,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [pgf_pkg::DIST_BITS-1:0]        distance,
  output logic [pgf_pkg::FORCE_W-1:0]          force_res,
  output logic                                 clamped,
  output logic                                 status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pgf_pkg::GAIN_W-1:0]      cfg_data
);
  localparam int DEN_W = pgf_pkg::den_w(COORD_BITS);
  localparam int N_W = pgf_pkg::num_w(MASS_BITS);
  localparam int MID_W = N_W + DEN_W + 2;
  localparam int RES_W = pgf_pkg::DIST_BITS + pgf_pkg::FORCE_W + 2;

  logic [pgf_pkg::GAIN_W-1:0] force_gain;
  logic mid_full, mid_empty, mid_push, mid_pop;
  logic [MID_W-1:0] mid_wdata, mid_rdata;
  logic out_full, out_push;
  logic [RES_W-1:0] out_wdata, out_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_gain <= pgf_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      force_gain <= cfg_data;
    end
  end

  pgf_front #(.COORD_BITS(COORD_BITS), .MASS_BITS(MASS_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .a_x(a_x), .a_y(a_y), .a_radius(a_radius), .a_mass(a_mass),
    .b_x(b_x), .b_y(b_y), .b_radius(b_radius), .b_mass(b_mass),
    .gain(force_gain), .mid_full(mid_full), .mid_push(mid_push), .mid_data(mid_wdata)
  );

  pgf_fifo #(.W(MID_W), .DEPTH(pgf_pkg::MID_DEPTH)) u_mid (
    .clk(clk), .rst(rst), .wr_en(mid_push), .wr_data(mid_wdata), .full(mid_full),
    .rd_en(mid_pop), .rd_data(mid_rdata), .empty(mid_empty)
  );

  pgf_back #(.COORD_BITS(COORD_BITS), .MASS_BITS(MASS_BITS)) u_back (
    .clk(clk), .rst(rst), .mid_empty(mid_empty), .mid_data(mid_rdata), .mid_pop(mid_pop),
    .out_full(out_full), .out_push(out_push), .out_data(out_wdata)
  );

  pgf_fifo #(.W(RES_W), .DEPTH(pgf_pkg::OUT_DEPTH)) u_out (
    .clk(clk), .rst(rst), .wr_en(out_push), .wr_data(out_wdata), .full(out_full),
    .rd_en(pop), .rd_data(out_rdata), .empty(empty)
  );

  assign {distance, force_res, clamped, status} = out_rdata;

  a_status_force: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (force_res == '1))
    else $error("zero denominator result without saturated force");

  a_status_dist: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (distance == '0 && !clamped))
    else $error("zero denominator result with nonzero distance or clamp");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");
endmodule
`default_nettype wire

FILE: tb/pair_gravity_force_tb.sv
// self-checking testbench for the pair gravity force block
`default_nettype none
module pair_gravity_force_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = pgf_pkg::COORD_BITS_DEF;
  localparam int MB = pgf_pkg::MASS_BITS_DEF;
  localparam int RADIUS_BITS = pgf_pkg::RADIUS_BITS;
  localparam int DIST_BITS = pgf_pkg::DIST_BITS;
  localparam int FORCE_W = pgf_pkg::FORCE_W;
  localparam int GAIN_W = pgf_pkg::GAIN_W;
  localparam int FRAC_SHIFT = pgf_pkg::FRAC_SHIFT;
  localparam logic [GAIN_W-1:0] GAIN_RESET = pgf_pkg::GAIN_RESET;
  localparam int LATENCY = 70;
  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 1730;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay;
    logic [RADIUS_BITS-1:0] ar;
    logic [MB-1:0] am;
    logic signed [CB-1:0] bx, by;
    logic [RADIUS_BITS-1:0] br;
    logic [MB-1:0] bm;
  } pair_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] dlen;
    logic [FORCE_W-1:0] frc;
    logic clmp;
    logic stat;
  } force_t;

  typedef struct {
    pair_t p;
    bit known;
    force_t r;
  } row_t;

  logic clk, rst, push, full, empty, pop, clamped, status, cfg_valid, cfg_ready;
  logic signed [CB-1:0] a_x, a_y, b_x, b_y;
  logic [RADIUS_BITS-1:0] a_radius, b_radius;
  logic [MB-1:0] a_mass, b_mass;
  logic [DIST_BITS-1:0] distance;
  logic [FORCE_W-1:0] force_res;
  logic [GAIN_W-1:0] cfg_data;

  pair_gravity_force DUT (.*);

  logic [GAIN_W-1:0] gain_q;
  force_t pending_forces[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_gap = 0;
  bit timed_out = 0;
  bit rx_free = 0;
  bit hold_rx = 0;
  bit items_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic force_t calc_force(pair_t p, logic [GAIN_W-1:0] g);
    force_t r;
    logic signed [CB:0] dx, dy;
    logic [63:0] d2, r2, den, root;
    logic [24:0] rsum;
    logic [127:0] num, q;
    dx = p.ax - p.bx;
    dy = p.ay - p.by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    d2 = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
    rsum = p.ar + p.br;
    r2 = 64'(rsum) * 64'(rsum);
    r.clmp = d2 < r2;
    den = r.clmp ? r2 : d2;
    root = isqrt(den);
    r.dlen = (root > 64'((1 << DIST_BITS) - 1)) ? '1 : root[DIST_BITS-1:0];
    if (den == 0) begin
      r.frc = '1;
      r.stat = 1;
    end else begin
      num = (128'(p.am) * 128'(p.bm) * 128'(g)) >> FRAC_SHIFT;
      q = num / 128'(den);
      r.frc = (q[127:64] != 0) ? '1 : q[63:0];
      r.stat = 0;
    end
    return r;
  endfunction

  function automatic pair_t rand_pair(int kind);
    pair_t p;
    logic [223:0] rbits;
    rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = rbits[$bits(pair_t)-1:0];
    case (kind % 4)
      0: begin
        p.ar = RADIUS_BITS'($urandom_range(0, 1000));
        p.br = RADIUS_BITS'($urandom_range(0, 1000));
        p.bx = CB'(p.ax + $signed(CB'($urandom_range(0, 4000))) - 2000);
        p.by = CB'(p.ay + $signed(CB'($urandom_range(0, 4000))) - 2000);
      end
      1: begin
        p.bx = p.ax;
        p.by = p.ay;
        if ($urandom_range(0, 1)) begin
          p.ar = '0;
          p.br = '0;
        end
      end
      2: begin
        p.am = MB'($urandom_range(0, 1000));
        p.bm = MB'($urandom_range(0, 1000));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    push <= 1;
    {a_x, a_y, a_radius, a_mass, b_x, b_y, b_radius, b_mass} <= p;
    do @(posedge clk); while (full);
    pending_forces.push_back(calc_force(p, gain_q));
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] g);
    push <= 0;
    wait (pending_forces.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    gain_q = g;
  endtask

  task automatic sender_gap(bit allow);
    if (allow && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  row_t rows[$];
  task automatic add_row(pair_t p, bit known, force_t r);
    row_t x;
    x.p = p;
    x.known = known;
    x.r = r;
    rows.push_back(x);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result dist=%0d force=%0h", distance, force_res);
        end else begin
          force_t e;
          e = pending_forces.pop_front();
          if (e != {distance, force_res, clamped, status}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp dist=%0d force=%0h clamp=%0b stat=%0b got %0d %0h %0b %0b",
                       e.dlen, e.frc, e.clmp, e.stat, distance, force_res, clamped, status);
          end
        end
      end
      if (rx_free) begin
        pop <= 1;
      end else if (hold_rx) begin
        pop <= 0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        pop <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 13);
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  // stalls on the receiving side, one long and one short
  initial begin
    int i;
    wait (items_done == 0 && rows.size() > 0);
    repeat (600) @(posedge clk);
    hold_rx = 1;
    for (i = 0; i < 300; i++) @(posedge clk);
    hold_rx = 0;
    repeat (3000) @(posedge clk);
    hold_rx = 1;
    for (i = 0; i < 14; i++) @(posedge clk);
    hold_rx = 0;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("** pair_gravity_force: FAILED **");
      $finish;
    end
  end

  initial begin
    pair_t p;
    force_t r;
    int i;
    rst <= 1;
    push <= 0;
    cfg_valid <= 0;
    cfg_data <= 0;
    {a_x, a_y, a_radius, a_mass, b_x, b_y, b_radius, b_mass} <= '0;
    gain_q = GAIN_RESET;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    p = '0;
    r = '{dlen: 0, frc: '1, clmp: 0, stat: 1};
    add_row(p, 1, r);                     // zero denominator
    p.ar = RADIUS_BITS'(3); p.br = RADIUS_BITS'(4);
    r = '{dlen: 7, frc: 0, clmp: 1, stat: 0};
    add_row(p, 1, r);                     // clamped, no mass
    p = '0; p.ax = CB'(3); p.ay = CB'(4); p.ar = RADIUS_BITS'(2); p.br = RADIUS_BITS'(3);
    r = '{dlen: 5, frc: 0, clmp: 0, stat: 0};
    add_row(p, 1, r);                     // equal distance
    p = '0; p.ax = CB'(1); p.am = '1; p.bm = '1;
    add_row(p, 0, r);                     // force overflow
    p = '0; p.ax = {1'b0, {(CB-1){1'b1}}}; p.ay = p.ax;
    p.bx = {1'b1, {(CB-1){1'b0}}}; p.by = p.bx; p.am = '1; p.bm = '1;
    add_row(p, 0, r);
    p = '0; p.ar = '1; p.br = '1; p.am = '1; p.bm = MB'(1);
    add_row(p, 0, r);
    p = '0; p.ax = CB'(-5); p.by = CB'(7); p.am = MB'(1000); p.bm = MB'(123456);
    add_row(p, 0, r);
    p = '1; add_row(p, 0, r);
    p = '0; p.ax = CB'(100); p.am = 32'h8000_0000; p.bm = 32'h8000_0000;
    add_row(p, 0, r);

    foreach (rows[k]) begin
      if (rows[k].known) begin
        force_t e;
        e = calc_force(rows[k].p, gain_q);
        if (e != rows[k].r) begin
          mismatches++;
          $display("table row %0d disagrees with predictor", k);
        end
      end
      send_pair(rows[k].p);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 300) write_gain('1);
      if (i == 500) write_gain('0);
      if (i == 700) write_gain($urandom);
      if (i == 900) write_gain(32'd1);
      if (i == 1100) write_gain(GAIN_RESET);
      if (i == 1300) begin
        push <= 0;
        wait (pending_forces.size() == 0);
      end
      if (i == 1500) rx_free = 1;
      send_pair(rand_pair($urandom_range(0, 3)));
      sender_gap(i < 1500);
    end
    push <= 0;
    items_done = 1;
    wait (pending_forces.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_forces.size() == 0)
      $display("** pair_gravity_force: PASSED **");
    else
      $display("** pair_gravity_force: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
src/pgf_pkg.sv
src/pgf_fifo.sv
src/pgf_front.sv
src/pgf_back.sv
src/pair_gravity_force.sv
tb/pair_gravity_force_tb.sv
